[sv/segi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package segi_pkg;

	localparam int CoordWidth = 16;
	localparam int FracBits   = 4;

	// derived widths of the datapath
	localparam int DifWidth = CoordWidth + 1;
	localparam int PrdWidth = 2 * DifWidth;
	localparam int SumWidth = PrdWidth + 1;
	localparam int DvdWidth = SumWidth + DifWidth;
	localparam int QuoWidth = DifWidth;

	typedef struct packed {
		logic signed [CoordWidth-1:0] a_start_x;
		logic signed [CoordWidth-1:0] a_start_y;
		logic signed [CoordWidth-1:0] a_end_x;
		logic signed [CoordWidth-1:0] a_end_y;
		logic signed [CoordWidth-1:0] b_start_x;
		logic signed [CoordWidth-1:0] b_start_y;
		logic signed [CoordWidth-1:0] b_end_x;
		logic signed [CoordWidth-1:0] b_end_y;
	} seg_in_t;

	typedef struct packed {
		logic                         hit;
		logic signed [CoordWidth-1:0] cross_x;
		logic signed [CoordWidth-1:0] cross_y;
	} seg_out_t;

endpackage
`default_nettype wire

[sv/segment_intersection_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// segment_intersection_core: 2d segment intersection test
//
// input channel: a word of two segments is taken at a rising edge where
// start is high and busy is low; busy is never raised, so one word may
// enter in every cycle
// output channel: done strobes for exactly one cycle with the result
// word (hit flag and intersection point in the input fixed-point format)
// throughput: one word per cycle, from accept through s1 to s4, the divider
// stages and the output register to done
// the restoring divider yields one quotient bit per
// pipeline stage, QuoWidth stages for both axes side by side
// stages: differences, six products, cross sums, hit test and
// dividend multiply, divider, sign fix and add of the start point
// reset: arst_n clears all valid bits at once; words in flight are lost
// the receiver cannot stall: every result is presented exactly once
// on a miss the point fields are zero
module segment_intersection_core
	import segi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire seg_in_t  item,
	output logic          done,
	output seg_out_t      result
);

	localparam int Lat = QuoWidth + 5;

	// never held off: the pipe always advances
	assign busy = 1'b0;

	// ---------------------------------------------------------------- s1
	// direction vectors and offset, one bit wider than the coordinates
	logic                       vld_s1;
	logic signed [DifWidth-1:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, dx_s1, dy_s1;
	logic signed [CoordWidth-1:0] p0x_s1, p0y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		s1x_s1 <= {item.a_end_x[CoordWidth-1], item.a_end_x}
			- {item.a_start_x[CoordWidth-1], item.a_start_x};
		s1y_s1 <= {item.a_end_y[CoordWidth-1], item.a_end_y}
			- {item.a_start_y[CoordWidth-1], item.a_start_y};
		s2x_s1 <= {item.b_end_x[CoordWidth-1], item.b_end_x}
			- {item.b_start_x[CoordWidth-1], item.b_start_x};
		s2y_s1 <= {item.b_end_y[CoordWidth-1], item.b_end_y}
			- {item.b_start_y[CoordWidth-1], item.b_start_y};
		dx_s1  <= {item.a_start_x[CoordWidth-1], item.a_start_x}
			- {item.b_start_x[CoordWidth-1], item.b_start_x};
		dy_s1  <= {item.a_start_y[CoordWidth-1], item.a_start_y}
			- {item.b_start_y[CoordWidth-1], item.b_start_y};
		p0x_s1 <= item.a_start_x;
		p0y_s1 <= item.a_start_y;
	end

	// ---------------------------------------------------------------- s2
	// the six cross-product terms
	logic                       vld_s2;
	logic signed [PrdWidth-1:0] pd1_s2, pd2_s2, ps1_s2, ps2_s2, pt1_s2, pt2_s2;
	logic signed [DifWidth-1:0] s1x_s2, s1y_s2;
	logic signed [CoordWidth-1:0] p0x_s2, p0y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pd1_s2 <= PrdWidth'(s1x_s1 * s2y_s1);
		pd2_s2 <= PrdWidth'(s2x_s1 * s1y_s1);
		ps1_s2 <= PrdWidth'(s1x_s1 * dy_s1);
		ps2_s2 <= PrdWidth'(s1y_s1 * dx_s1);
		pt1_s2 <= PrdWidth'(s2x_s1 * dy_s1);
		pt2_s2 <= PrdWidth'(s2y_s1 * dx_s1);
		s1x_s2 <= s1x_s1;
		s1y_s2 <= s1y_s1;
		p0x_s2 <= p0x_s1;
		p0y_s2 <= p0y_s1;
	end

	// ---------------------------------------------------------------- s3
	// denominator and the two numerators
	logic                       vld_s3;
	logic signed [SumWidth-1:0] den_s3, ns_s3, nt_s3;
	logic signed [DifWidth-1:0] s1x_s3, s1y_s3;
	logic signed [CoordWidth-1:0] p0x_s3, p0y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3 <= {pd1_s2[PrdWidth-1], pd1_s2} - {pd2_s2[PrdWidth-1], pd2_s2};
		ns_s3  <= {ps1_s2[PrdWidth-1], ps1_s2} - {ps2_s2[PrdWidth-1], ps2_s2};
		nt_s3  <= {pt1_s2[PrdWidth-1], pt1_s2} - {pt2_s2[PrdWidth-1], pt2_s2};
		s1x_s3 <= s1x_s2;
		s1y_s3 <= s1y_s2;
		p0x_s3 <= p0x_s2;
		p0y_s3 <= p0y_s2;
	end

	// ---------------------------------------------------------------- s4
	// hit test on magnitudes and signs, then |nt| * |s1| per axis
	logic [SumWidth-1:0] den_mag, ns_mag, nt_mag;
	logic [DifWidth-1:0] s1x_mag, s1y_mag;
	logic                den_neg, ns_neg, nt_neg;
	logic                ns_ok, nt_ok, hit_c;

	always_comb begin
		den_neg = den_s3[SumWidth-1];
		ns_neg  = ns_s3[SumWidth-1];
		nt_neg  = nt_s3[SumWidth-1];
		den_mag = den_neg ? SumWidth'(-den_s3) : SumWidth'(den_s3);
		ns_mag  = ns_neg ? SumWidth'(-ns_s3) : SumWidth'(ns_s3);
		nt_mag  = nt_neg ? SumWidth'(-nt_s3) : SumWidth'(nt_s3);
		s1x_mag = s1x_s3[DifWidth-1] ? DifWidth'(-s1x_s3) : DifWidth'(s1x_s3);
		s1y_mag = s1y_s3[DifWidth-1] ? DifWidth'(-s1y_s3) : DifWidth'(s1y_s3);
		// zero numerator lies inside; else same sign and not beyond den
		ns_ok   = (ns_s3 == '0) || ((ns_neg == den_neg) && (ns_mag <= den_mag));
		nt_ok   = (nt_s3 == '0) || ((nt_neg == den_neg) && (nt_mag <= den_mag));
		hit_c   = (den_s3 != '0) && ns_ok && nt_ok;
	end

	// divider stage arrays: entry 0 is s4, entry QuoWidth the last bit
	logic                        vld_dv [QuoWidth+1];
	logic                        hit_dv [QuoWidth+1];
	logic                        ngx_dv [QuoWidth+1];
	logic                        ngy_dv [QuoWidth+1];
	logic [DvdWidth-1:0]         rmx_dv [QuoWidth+1];
	logic [DvdWidth-1:0]         rmy_dv [QuoWidth+1];
	logic [QuoWidth-1:0]         qux_dv [QuoWidth+1];
	logic [QuoWidth-1:0]         quy_dv [QuoWidth+1];
	logic [SumWidth-1:0]         dvs_dv [QuoWidth+1];
	logic signed [CoordWidth-1:0] p0x_dv [QuoWidth+1];
	logic signed [CoordWidth-1:0] p0y_dv [QuoWidth+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv[0] <= 1'b0;
		end else begin
			vld_dv[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_dv[0] <= hit_c;
		ngx_dv[0] <= nt_neg ^ s1x_s3[DifWidth-1] ^ den_neg;
		ngy_dv[0] <= nt_neg ^ s1y_s3[DifWidth-1] ^ den_neg;
		rmx_dv[0] <= DvdWidth'(nt_mag * s1x_mag);
		rmy_dv[0] <= DvdWidth'(nt_mag * s1y_mag);
		qux_dv[0] <= '0;
		quy_dv[0] <= '0;
		dvs_dv[0] <= den_mag;
		p0x_dv[0] <= p0x_s3;
		p0y_dv[0] <= p0y_s3;
	end

	// restoring divider, msb first; the quotient is known to fit in
	// QuoWidth bits on a hit, and a miss discards it
	for (genvar k = 0; k < QuoWidth; k++) begin : g_div
		localparam int Sh = QuoWidth - 1 - k;
		logic [DvdWidth-1:0] trial;
		logic                takex, takey;

		always_comb begin
			trial = DvdWidth'(dvs_dv[k]) << Sh;
			takex = rmx_dv[k] >= trial;
			takey = rmy_dv[k] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[k+1] <= 1'b0;
			end else begin
				vld_dv[k+1] <= vld_dv[k];
			end
		end

		always_ff @(posedge clk) begin
			rmx_dv[k+1] <= takex ? rmx_dv[k] - trial : rmx_dv[k];
			rmy_dv[k+1] <= takey ? rmy_dv[k] - trial : rmy_dv[k];
			qux_dv[k+1] <= {qux_dv[k][QuoWidth-2:0], takex};
			quy_dv[k+1] <= {quy_dv[k][QuoWidth-2:0], takey};
			hit_dv[k+1] <= hit_dv[k];
			ngx_dv[k+1] <= ngx_dv[k];
			ngy_dv[k+1] <= ngy_dv[k];
			dvs_dv[k+1] <= dvs_dv[k];
			p0x_dv[k+1] <= p0x_dv[k];
			p0y_dv[k+1] <= p0y_dv[k];
		end
	end

	// ---------------------------------------------------------------- out
	// sign the quotient and add the start of segment a
	logic signed [DifWidth-1:0] offx, offy;
	logic signed [DifWidth-1:0] sumx, sumy;
	logic                       done_q;
	seg_out_t                   res_q;

	always_comb begin
		offx = ngx_dv[QuoWidth] ? -$signed(qux_dv[QuoWidth]) : $signed(qux_dv[QuoWidth]);
		offy = ngy_dv[QuoWidth] ? -$signed(quy_dv[QuoWidth]) : $signed(quy_dv[QuoWidth]);
		sumx = {p0x_dv[QuoWidth][CoordWidth-1], p0x_dv[QuoWidth]} + offx;
		sumy = {p0y_dv[QuoWidth][CoordWidth-1], p0y_dv[QuoWidth]} + offy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dv[QuoWidth];
		end
	end

	always_ff @(posedge clk) begin
		res_q.hit     <= hit_dv[QuoWidth];
		res_q.cross_x <= hit_dv[QuoWidth] ? sumx[CoordWidth-1:0] : '0;
		res_q.cross_y <= hit_dv[QuoWidth] ? sumy[CoordWidth-1:0] : '0;
	end

	assign done   = done_q;
	assign result = res_q;

	// ---------------------------------------------------------------- checks
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Lat))
		else $error("result without a word accepted at the pipeline latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.cross_x == '0 && result.cross_y == '0))
		else $error("miss with a nonzero point");

endmodule
`default_nettype wire
